// ===== design/optmac_pkg.sv =====
// ----------------------------------------------------------------------------
// optmac_pkg
// Shared types and constants of the outer-product tile MAC: input lane
// layout, per-cell control word, drain status and drain sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package optmac_pkg;

	// Input stream layout: four 64-bit fields, four 16-bit lanes each
	localparam int unsigned FIELD_BITS      = 64;
	localparam int unsigned IN_TDATA_WIDTH  = 4 * FIELD_BITS;
	localparam int unsigned LANE_BITS       = 16;
	localparam int unsigned LANES_PER_FIELD = 4;
	localparam int unsigned IN_LANES        = 8;

	// Row and column indexes on the output are three bits wide
	localparam int unsigned IDX_BITS = 3;

	// Control word broadcast to every cell of the chain
	typedef struct packed {
		logic mul_en;   // capture this step's product
		logic acc_en;   // add the captured product into the sum
		logic shift_en; // move every sum one cell toward the head
	} cell_ctrl_t;

	// Status returned by the drain sequencer
	typedef struct packed {
		logic busy;  // drain in progress
		logic shift; // chain advances this cycle
	} drain_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} drain_state_t;

endpackage

`default_nettype wire

// ===== design/optmac_cell.sv =====
// ----------------------------------------------------------------------------
// optmac_cell
// One accumulator of the tile: registered product, saturating accumulate,
// and a shift path from the neighbor cell used to unload the sums.
// ----------------------------------------------------------------------------
`default_nettype none

module optmac_cell #(
	parameter int unsigned DATA_WIDTH = 16,
	parameter int unsigned ACC_WIDTH  = 48
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  optmac_pkg::cell_ctrl_t           ctrl,
	input  wire logic signed [DATA_WIDTH-1:0] a,
	input  wire logic signed [DATA_WIDTH-1:0] b,
	input  wire logic signed [ACC_WIDTH-1:0]  shift_in,
	output logic signed [ACC_WIDTH-1:0]       acc
);

	import optmac_pkg::*;

	localparam int unsigned PROD_WIDTH = 2 * DATA_WIDTH;

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	logic signed [PROD_WIDTH-1:0] prod_s1;
	logic signed [ACC_WIDTH-1:0]  acc_q;
	logic signed [ACC_WIDTH:0]    sum;
	logic signed [ACC_WIDTH-1:0]  sat_sum;

	// Register the product of this step
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= PROD_WIDTH'(a) * PROD_WIDTH'(b);
		end
	end

	// Add with one guard bit, clamp when the two top bits disagree
	always_comb begin
		sum = {acc_q[ACC_WIDTH-1], acc_q} + (ACC_WIDTH+1)'(prod_s1);
		if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
			sat_sum = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end else begin
			sat_sum = sum[ACC_WIDTH-1:0];
		end
	end

	// Hold the sum; shift toward the head while unloading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.shift_en) begin
			acc_q <= shift_in;
		end else if (ctrl.acc_en) begin
			acc_q <= sat_sum;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== design/optmac_drain.sv =====
// ----------------------------------------------------------------------------
// optmac_drain
// Unload sequencer: steps the cell chain once per free output slot, tags
// each sum with its row and column and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module optmac_drain #(
	parameter int unsigned TILE_ROWS = 8,
	parameter int unsigned TILE_COLS = 8,
	parameter int unsigned ACC_WIDTH = 48
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire logic signed [ACC_WIDTH-1:0]     head,
	input  wire                                  out_ready,
	output optmac_pkg::drain_stat_t              stat,
	output logic                                 out_valid,
	output logic [optmac_pkg::IDX_BITS-1:0]      out_row,
	output logic [optmac_pkg::IDX_BITS-1:0]      out_col,
	output logic signed [ACC_WIDTH-1:0]          out_value,
	output logic                                 out_last
);

	import optmac_pkg::*;

	localparam int unsigned RW = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int unsigned CW = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
	localparam logic [RW-1:0] ROW_END = RW'(TILE_ROWS - 1);
	localparam logic [CW-1:0] COL_END = CW'(TILE_COLS - 1);

	drain_state_t state_q, state_d;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          at_end;
	logic          shift;
	logic [RW+IDX_BITS-1:0] row_ext;
	logic [CW+IDX_BITS-1:0] col_ext;

	logic                        out_valid_q;
	logic [IDX_BITS-1:0]         out_row_q;
	logic [IDX_BITS-1:0]         out_col_q;
	logic signed [ACC_WIDTH-1:0] out_value_q;
	logic                        out_last_q;

	assign at_end  = (row_q == ROW_END) && (col_q == COL_END);
	assign row_ext = (RW+IDX_BITS)'(row_q);
	assign col_ext = (CW+IDX_BITS)'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state; during a drain, advance the chain whenever the output slot is free
	always_comb begin
		state_d = state_q;
		shift   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				shift = !out_valid_q || out_ready;
				if (shift && at_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Walk the tile in row-major order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (start) begin
			row_q <= '0;
			col_q <= '0;
		end else if (shift) begin
			if (col_q == COL_END) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Output register: load on shift, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (shift) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			out_row_q   <= row_ext[IDX_BITS-1:0];
			out_col_q   <= col_ext[IDX_BITS-1:0];
			out_value_q <= head;
			out_last_q  <= at_end;
		end
	end

	assign stat.busy  = (state_q == ST_DRAIN);
	assign stat.shift = shift;
	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;

	// A full output register that is not taken must not be overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !shift)
		else $error("optmac_drain: output overwritten while stalled");

	// The final sum of the tile closes the drain
	assert property (@(posedge clk) disable iff (!arst_n)
		(shift && at_end) |=> (state_q == ST_IDLE) && out_last_q)
		else $error("optmac_drain: drain did not close on the final sum");

	// A new drain only starts from idle
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == ST_IDLE))
		else $error("optmac_drain: start while draining");

endmodule

`default_nettype wire

// ===== design/outer_product_tile_mac_unit.sv =====
// ----------------------------------------------------------------------------
// outer_product_tile_mac_unit
// TILE_ROWS x TILE_COLS outer-product multiply-accumulate tile with a
// shift-out chain for unloading the sums.
// ----------------------------------------------------------------------------
// Each input transfer is one k step: a column of A (rows 0-3 in the first
// 64-bit field, rows 4-7 in the second) and a row of B (columns 0-3, then
// 4-7), 16-bit lanes whose low DATA_WIDTH bits are read as signed values.
// Every cell of the chain owns one accumulator, multiplies its A and B lane
// and adds the product in the cycle after, clamping at the ACC_WIDTH limits.
// Ordinary steps are taken one per cycle while the input is not held off. A
// step with tlast set is added in, then the sums leave in row-major order,
// one per cycle while the output is not stalled, as the chain shifts toward
// its head and fills with zeros from the tail. After the step with tlast
// the input is held off until the unload is done, which is paced by the
// single output register at the head of the chain and so by any output
// stall. The accumulators are zero after reset and after each unload.
// ----------------------------------------------------------------------------
`default_nettype none

module outer_product_tile_mac_unit #(
	parameter int unsigned TILE_ROWS  = 8,
	parameter int unsigned TILE_COLS  = 8,
	parameter int unsigned DATA_WIDTH = 16,
	parameter int unsigned ACC_WIDTH  = 48
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	// a_low [63:0], a_high [127:64], b_low [191:128], b_high [255:192]
	input  wire  [optmac_pkg::IN_TDATA_WIDTH-1:0]        s_axis_tdata,
	input  wire                                          s_axis_tvalid,
	output logic                                         s_axis_tready,
	input  wire                                          s_axis_tlast,
	// row [2:0], col [5:3], value [ACC_WIDTH+5:6], zero padding above
	output logic [((2*optmac_pkg::IDX_BITS+ACC_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	output logic                                         m_axis_tvalid,
	input  wire                                          m_axis_tready,
	output logic                                         m_axis_tlast
);

	import optmac_pkg::*;

	localparam int unsigned NCELLS     = TILE_ROWS * TILE_COLS;
	localparam int unsigned OUT_TDATA_W = ((2*IDX_BITS + ACC_WIDTH + 7) / 8) * 8;

	logic signed [DATA_WIDTH-1:0] a_lane [TILE_ROWS];
	logic signed [DATA_WIDTH-1:0] b_lane [TILE_COLS];
	logic signed [ACC_WIDTH-1:0]  acc_w  [NCELLS];

	logic        in_xfer;
	logic        s1_valid_q;
	logic        s1_last_q;
	logic        drain_start;
	cell_ctrl_t  ctrl;
	drain_stat_t dstat;

	logic [IDX_BITS-1:0]         out_row;
	logic [IDX_BITS-1:0]         out_col;
	logic signed [ACC_WIDTH-1:0] out_value;

	// Unpack A lanes; rows without an input lane read as zero
	for (genvar r = 0; r < TILE_ROWS; r++) begin : g_a_lane
		if (r < IN_LANES) begin : g_live
			localparam int unsigned LO = (r / LANES_PER_FIELD) * FIELD_BITS
				+ (r % LANES_PER_FIELD) * LANE_BITS;
			assign a_lane[r] = s_axis_tdata[LO +: DATA_WIDTH];
		end else begin : g_zero
			assign a_lane[r] = '0;
		end
	end

	// Unpack B lanes from the upper two fields
	for (genvar c = 0; c < TILE_COLS; c++) begin : g_b_lane
		if (c < IN_LANES) begin : g_live
			localparam int unsigned LO = (2 + c / LANES_PER_FIELD) * FIELD_BITS
				+ (c % LANES_PER_FIELD) * LANE_BITS;
			assign b_lane[c] = s_axis_tdata[LO +: DATA_WIDTH];
		end else begin : g_zero
			assign b_lane[c] = '0;
		end
	end

	// Hold input off while a closing step is in flight or the tile unloads
	assign s_axis_tready = !dstat.busy && !(s1_valid_q && s1_last_q);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Track the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_last_q  <= 1'b0;
		end else begin
			s1_valid_q <= in_xfer;
			s1_last_q  <= in_xfer && s_axis_tlast;
		end
	end

	assign drain_start   = s1_valid_q && s1_last_q;
	assign ctrl.mul_en   = in_xfer;
	assign ctrl.acc_en   = s1_valid_q;
	assign ctrl.shift_en = dstat.shift;

	// Chain of cells in row-major order; the tail takes in zeros
	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		logic signed [ACC_WIDTH-1:0] nb;
		if (i == NCELLS - 1) begin : g_tail
			assign nb = '0;
		end else begin : g_link
			assign nb = acc_w[i+1];
		end
		optmac_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.ACC_WIDTH  (ACC_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.a        (a_lane[i / TILE_COLS]),
			.b        (b_lane[i % TILE_COLS]),
			.shift_in (nb),
			.acc      (acc_w[i])
		);
	end

	optmac_drain #(
		.TILE_ROWS (TILE_ROWS),
		.TILE_COLS (TILE_COLS),
		.ACC_WIDTH (ACC_WIDTH)
	) u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (drain_start),
		.head      (acc_w[0]),
		.out_ready (m_axis_tready),
		.stat      (dstat),
		.out_valid (m_axis_tvalid),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_TDATA_W'({out_value, out_col, out_row});

	// Accumulate and unload never overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.acc_en && ctrl.shift_en))
		else $error("optmac: accumulate during unload");

	// A closing step blocks the next transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tlast) |=> !s_axis_tready)
		else $error("optmac: input taken behind a closing step");

	// The unload starts right after the closing step is summed
	assert property (@(posedge clk) disable iff (!arst_n)
		drain_start |=> dstat.busy)
		else $error("optmac: unload did not start");

endmodule

`default_nettype wire
